[rtl/fmi_pkg.sv]
// shared constants, microcode format and arithmetic helper of the modular inverse block
`timescale 1ns / 1ps

package fmi_pkg;

  // field widths
  localparam int MOD_BITS   = 31;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int EBIT_BITS  = $clog2(MOD_BITS);
  localparam int PC_BITS    = 4;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);

  // datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_GCD     = 4'd2;
  localparam logic [3:0] OP_MODINIT = 4'd3;
  localparam logic [3:0] OP_MODSTEP = 4'd4;
  localparam logic [3:0] OP_EXPINIT = 4'd5;
  localparam logic [3:0] OP_SQINIT  = 4'd6;
  localparam logic [3:0] OP_MULSTEP = 4'd7;
  localparam logic [3:0] OP_ACC     = 4'd8;
  localparam logic [3:0] OP_MLINIT  = 4'd9;
  localparam logic [3:0] OP_EXPNEXT = 4'd10;
  localparam logic [3:0] OP_SETOK   = 4'd11;
  localparam logic [3:0] OP_SETFAIL = 4'd12;
  localparam logic [3:0] OP_FINISH  = 4'd13;

  // jump conditions
  localparam logic [3:0] C_NEVER       = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_NO_REQ      = 4'd2;
  localparam logic [3:0] C_MOD_SMALL   = 4'd3;
  localparam logic [3:0] C_GCD_BUSY    = 4'd4;
  localparam logic [3:0] C_NOT_COPRIME = 4'd5;
  localparam logic [3:0] C_CNT_NZ      = 4'd6;
  localparam logic [3:0] C_EBIT_CLR    = 4'd7;
  localparam logic [3:0] C_EBIT_NZ     = 4'd8;
  localparam logic [3:0] C_OUT_BLOCKED = 4'd9;

  // program steps
  localparam logic [PC_BITS-1:0] P_WAIT    = 4'd0;
  localparam logic [PC_BITS-1:0] P_CHKM    = 4'd1;
  localparam logic [PC_BITS-1:0] P_GCD     = 4'd2;
  localparam logic [PC_BITS-1:0] P_GCDCHK  = 4'd3;
  localparam logic [PC_BITS-1:0] P_MODINIT = 4'd4;
  localparam logic [PC_BITS-1:0] P_MODSTEP = 4'd5;
  localparam logic [PC_BITS-1:0] P_EXPINIT = 4'd6;
  localparam logic [PC_BITS-1:0] P_SQINIT  = 4'd7;
  localparam logic [PC_BITS-1:0] P_SQSTEP  = 4'd8;
  localparam logic [PC_BITS-1:0] P_SQDONE  = 4'd9;
  localparam logic [PC_BITS-1:0] P_MLINIT  = 4'd10;
  localparam logic [PC_BITS-1:0] P_MLSTEP  = 4'd11;
  localparam logic [PC_BITS-1:0] P_EXPNEXT = 4'd12;
  localparam logic [PC_BITS-1:0] P_SETOK   = 4'd13;
  localparam logic [PC_BITS-1:0] P_SETFAIL = 4'd14;
  localparam logic [PC_BITS-1:0] P_FINISH  = 4'd15;

  // one control word
  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         cond;
    logic [PC_BITS-1:0] target;
  } ctrl_word_t;

  // microcode rom
  function automatic ctrl_word_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      P_WAIT:    cw = '{OP_LOAD,    C_NO_REQ,      P_WAIT};
      P_CHKM:    cw = '{OP_NOP,     C_MOD_SMALL,   P_SETFAIL};
      P_GCD:     cw = '{OP_GCD,     C_GCD_BUSY,    P_GCD};
      P_GCDCHK:  cw = '{OP_NOP,     C_NOT_COPRIME, P_SETFAIL};
      P_MODINIT: cw = '{OP_MODINIT, C_NEVER,       P_WAIT};
      P_MODSTEP: cw = '{OP_MODSTEP, C_CNT_NZ,      P_MODSTEP};
      P_EXPINIT: cw = '{OP_EXPINIT, C_NEVER,       P_WAIT};
      P_SQINIT:  cw = '{OP_SQINIT,  C_NEVER,       P_WAIT};
      P_SQSTEP:  cw = '{OP_MULSTEP, C_CNT_NZ,      P_SQSTEP};
      P_SQDONE:  cw = '{OP_ACC,     C_EBIT_CLR,    P_EXPNEXT};
      P_MLINIT:  cw = '{OP_MLINIT,  C_NEVER,       P_WAIT};
      P_MLSTEP:  cw = '{OP_MULSTEP, C_CNT_NZ,      P_MLSTEP};
      P_EXPNEXT: cw = '{OP_EXPNEXT, C_EBIT_NZ,     P_SQINIT};
      P_SETOK:   cw = '{OP_SETOK,   C_ALWAYS,      P_FINISH};
      P_SETFAIL: cw = '{OP_SETFAIL, C_NEVER,       P_WAIT};
      P_FINISH:  cw = '{OP_FINISH,  C_OUT_BLOCKED, P_FINISH};
      default:   cw = '{OP_NOP,     C_ALWAYS,      P_WAIT};
    endcase
    return cw;
  endfunction

  // (x + y) mod m for x, y below m
  function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] x,
                                                  input logic [MOD_BITS-1:0] y,
                                                  input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS-1:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

endpackage

[rtl/fermat_modular_inverse.sv]
// modular inverse by gcd check and square-and-multiply, driven by a microcode rom
// sequence: a modulus below two gives no inverse; otherwise a binary gcd, and a value not
// coprime to the modulus gives no inverse; otherwise a restoring reduction of the value, then
// a square per exponent bit plus a multiply per one bit (bit-serial modular multiplier)
// throughput: one request at a time; the next is taken once the result is registered
// reset: synchronous on rst; clears the sequencer and output valid, modulus to 1000000007
`timescale 1ns / 1ps

module fermat_modular_inverse
  import fmi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [MOD_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MOD_BITS-1:0]   inverse,
  output logic                  no_inverse
);

  logic [MOD_BITS-1:0]   modulus;
  logic [PC_BITS-1:0]    pc;
  ctrl_word_t            cw;
  logic                  jump;

  logic [VALUE_BITS-1:0] ga;
  logic [VALUE_BITS-1:0] gb;
  logic [VALUE_BITS-1:0] vreg;
  logic [MOD_BITS-1:0]   rem;
  logic [MOD_BITS-1:0]   base;
  logic [MOD_BITS-1:0]   acc;
  logic [MOD_BITS-1:0]   opa;
  logic [MOD_BITS-1:0]   opb;
  logic [MOD_BITS-1:0]   r;
  logic [CNT_BITS-1:0]   cnt;
  logic [EBIT_BITS-1:0]  ebit;
  logic                  none;

  logic [MOD_BITS-1:0]   exponent;
  logic                  gcd_busy;
  logic                  coprime;
  logic                  out_blocked;
  logic [VALUE_BITS-1:0] rem_sh;
  logic [VALUE_BITS-1:0] rem_sub;
  logic [MOD_BITS-1:0]   rem_next;
  logic [MOD_BITS-1:0]   r_dbl;
  logic [MOD_BITS-1:0]   r_add;
  logic [MOD_BITS-1:0]   r_next;

  // control word of the current step
  assign cw          = ucode(pc);
  assign in_stall    = (pc != P_WAIT);
  assign out_blocked = out_valid & out_stall;
  assign exponent    = modulus - MOD_BITS'(2);

  // binary gcd status
  assign gcd_busy = (ga != '0) && (gb != '0) && !(!ga[0] && !gb[0]);
  assign coprime  = ((ga == '0) && (gb == VALUE_BITS'(1))) ||
                    ((ga == VALUE_BITS'(1)) && (gb == '0));

  // one restoring remainder bit
  assign rem_sh   = {rem, vreg[cnt]};
  assign rem_sub  = rem_sh - {1'b0, modulus};
  assign rem_next = (rem_sh >= {1'b0, modulus}) ? rem_sub[MOD_BITS-1:0]
                                                : rem_sh[MOD_BITS-1:0];

  // one multiplier bit: double then conditionally add
  assign r_dbl  = add_mod(r, r, modulus);
  assign r_add  = add_mod(r_dbl, opa, modulus);
  assign r_next = opb[cnt[EBIT_BITS-1:0]] ? r_add : r_dbl;

  // jump condition decode
  always_comb begin
    unique case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_REQ:      jump = !in_valid;
      C_MOD_SMALL:   jump = (modulus < MOD_BITS'(2));
      C_GCD_BUSY:    jump = gcd_busy;
      C_NOT_COPRIME: jump = !coprime;
      C_CNT_NZ:      jump = (cnt != '0);
      C_EBIT_CLR:    jump = !exponent[ebit];
      C_EBIT_NZ:     jump = (ebit != '0);
      C_OUT_BLOCKED: jump = out_blocked;
      default:       jump = 1'b0;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_WAIT;
    end else if (jump) begin
      pc <= cw.target;
    end else begin
      pc <= pc + PC_BITS'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        ga   <= value;
        gb   <= {1'b0, modulus};
        vreg <= value;
      end
      OP_GCD: begin
        if (gcd_busy) begin
          if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
      end
      OP_MODINIT: begin
        rem <= '0;
        cnt <= CNT_BITS'(VALUE_BITS - 1);
      end
      OP_MODSTEP: begin
        rem  <= rem_next;
        base <= rem_next;
        cnt  <= cnt - CNT_BITS'(1);
      end
      OP_EXPINIT: begin
        acc  <= MOD_BITS'(1);
        ebit <= EBIT_BITS'(MOD_BITS - 1);
      end
      OP_SQINIT: begin
        opa <= acc;
        opb <= acc;
        r   <= '0;
        cnt <= CNT_BITS'(MOD_BITS - 1);
      end
      OP_MLINIT: begin
        opa <= acc;
        opb <= base;
        r   <= '0;
        cnt <= CNT_BITS'(MOD_BITS - 1);
      end
      OP_MULSTEP: begin
        r   <= r_next;
        cnt <= cnt - CNT_BITS'(1);
      end
      OP_ACC: begin
        acc <= r;
      end
      OP_EXPNEXT: begin
        acc  <= r;
        ebit <= ebit - EBIT_BITS'(1);
      end
      OP_SETOK: begin
        none <= 1'b0;
      end
      OP_SETFAIL: begin
        acc  <= '0;
        none <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_FINISH && !out_blocked) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cw.op == OP_FINISH && !out_blocked) begin
      inverse    <= acc;
      no_inverse <= none;
    end
  end

endmodule

[tb/sv/fermat_modular_inverse_checker.sv]
// checker for the modular inverse block: predicts each answer and compares it on delivery
`timescale 1ns / 1ps

module fermat_modular_inverse_checker
  import fmi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [MOD_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [MOD_BITS-1:0]   inverse,
  input  logic                  no_inverse,
  output int unsigned           waiting,
  output int unsigned           mismatches,
  output int unsigned           checked,
  output int unsigned           flagged
);

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic                none;
  } answer_t;

  answer_t             owed_answers[$];
  logic [MOD_BITS-1:0] modulus_q;
  int unsigned         mismatch_cnt = 0;
  int unsigned         checked_cnt  = 0;
  int unsigned         flagged_cnt  = 0;

  // gcd test, then value^(m-2) mod m by square-and-multiply on the reduced value
  function automatic answer_t fermat_inverse(input logic [VALUE_BITS-1:0] v,
                                             input logic [MOD_BITS-1:0]   m);
    longint unsigned a;
    longint unsigned b;
    longint unsigned t;
    longint unsigned mm;
    longint unsigned base;
    longint unsigned acc;
    logic [63:0]     power;
    answer_t         ans;
    ans.residue = '0;
    ans.none    = 1'b1;
    mm = m;
    if (mm >= 2) begin
      a = v;
      b = mm;
      while (a != 0) begin
        t = b % a;
        b = a;
        a = t;
      end
      if (b == 1) begin
        base  = v % mm;
        acc   = 1 % mm;
        power = mm - 2;
        for (int i = MOD_BITS - 1; i >= 0; i--) begin
          acc = (acc * acc) % mm;
          if (power[i]) begin
            acc = (acc * base) % mm;
          end
        end
        ans.residue = acc[MOD_BITS-1:0];
        ans.none    = 1'b0;
      end
    end
    return ans;
  endfunction

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      modulus_q = MOD_RESET;
      owed_answers.delete();
    end else begin
      // a request is priced with the modulus in force when it is taken
      if (in_valid && !in_stall) begin
        owed_answers.push_back(fermat_inverse(value, modulus_q));
      end
      // delivered answer against the oldest one owed
      if (out_valid && !out_stall) begin
        if (owed_answers.size() == 0) begin
          $error("answer with no request pending: inverse %0d, no_inverse %0b",
                 inverse, no_inverse);
          mismatch_cnt++;
        end else begin
          want = owed_answers.pop_front();
          checked_cnt++;
          if (no_inverse === 1'b1) begin
            flagged_cnt++;
          end
          if (inverse !== want.residue) begin
            $error("inverse: expected %0d, got %0d", want.residue, inverse);
            mismatch_cnt++;
          end
          if (no_inverse !== want.none) begin
            $error("no_inverse: expected %0b, got %0b", want.none, no_inverse);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we) begin
        modulus_q = cfg_data;
      end
    end
    // published late so the stimulus side never races the update
    waiting    <= owed_answers.size();
    mismatches <= mismatch_cnt;
    checked    <= checked_cnt;
    flagged    <= flagged_cnt;
  end

endmodule

[tb/sv/fermat_modular_inverse_test.sv]
// top of the modular inverse regression: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module fermat_modular_inverse_test
  import fmi_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT       = 60_000_000;
  localparam int unsigned REQS_PER_SETTING  = 170;
  localparam int unsigned DRAIN_CYCLES      = 2500;
  localparam int unsigned HOLD_OFF_START    = 60_000;
  localparam int unsigned HOLD_OFF_CYCLES   = 8_000;
  localparam int unsigned SETTING_COUNT     = 12;

  localparam logic [VALUE_BITS-1:0] DIRECTED_VALUES [12] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd1000000006, 32'd1000000007, 32'd1000000008,
    32'd2000000014, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd500000004
  };

  typedef enum logic [1:0] {FLOW, COIN, MOSTLY_STALLED, HOLD_OFF} stall_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [MOD_BITS-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value;
  logic                  out_valid;
  logic                  out_stall;
  logic [MOD_BITS-1:0]   inverse;
  logic                  no_inverse;

  int unsigned waiting;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned flagged;
  int unsigned burst_left;
  int unsigned cycle_cnt;

  fermat_modular_inverse u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inverse    (inverse),
    .no_inverse (no_inverse)
  );

  fermat_modular_inverse_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inverse    (inverse),
    .no_inverse (no_inverse),
    .waiting    (waiting),
    .mismatches (mismatches),
    .checked    (checked),
    .flagged    (flagged)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // value mix: plain random, below the modulus, multiples of it, tiny and near the edges
  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [MOD_BITS-1:0] m);
    longint unsigned       mm;
    longint unsigned       k;
    logic [VALUE_BITS-1:0] v;
    mm = m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = (mm != 0) ? $urandom_range(0, 32'(mm - 1)) : $urandom;
      6: begin
        if (mm != 0) begin
          k = $urandom_range(0, 32'(64'hFFFF_FFFF / mm));
          v = 32'(k * mm);
        end else begin
          v = '0;
        end
      end
      7:          v = $urandom_range(0, 3);
      8:          v = 32'(mm) + $urandom_range(0, 2) - 1;
      default:    v = 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  // offer one request, in bursts with random gaps between them
  task automatic offer_request(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // register write once every owed answer has come back
  task automatic set_modulus(input logic [MOD_BITS-1:0] m);
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // receiver back-pressure, with one long hold-off so the block backs up
  initial begin
    stall_mode_t mode;
    int unsigned span;
    int unsigned rx_cycles;
    bit          held_off;
    out_stall = 1'b0;
    rx_cycles = 0;
    held_off  = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 600);
      if (!held_off && rx_cycles >= HOLD_OFF_START) begin
        mode     = HOLD_OFF;
        span     = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end
      repeat (span) begin
        @(posedge clk);
        rx_cycles++;
        case (mode)
          FLOW:           out_stall <= 1'b0;
          COIN:           out_stall <= 1'($urandom_range(0, 1));
          MOSTLY_STALLED: out_stall <= ($urandom_range(0, 3) != 0);
          default:        out_stall <= 1'b1;
        endcase
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("fermat_modular_inverse regression: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [MOD_BITS-1:0] settings [SETTING_COUNT];
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    value      = '0;
    burst_left = 0;
    // reset value, all ones, the degenerate moduli, small and large primes, composites
    settings = '{MOD_RESET, 31'h7FFF_FFFF, 31'd2, 31'd0, 31'd1, 31'd3, 31'd4,
                 31'd65537, 31'd998244353, 31'h7FFF_FFFE,
                 31'($urandom | 1), 31'($urandom)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // edge values under the reset modulus
    foreach (DIRECTED_VALUES[i]) begin
      offer_request(DIRECTED_VALUES[i]);
    end

    // random requests under each modulus setting
    for (int s = 0; s < SETTING_COUNT; s++) begin
      if (s != 0) begin
        set_modulus(settings[s]);
      end
      repeat (REQS_PER_SETTING) offer_request(pick_value(settings[s]));
    end

    // drain, then give stray answers time to show
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests under %0d modulus settings in %0d cycles",
             checked, SETTING_COUNT, cycle_cnt);
    $display("%0d answers flagged no inverse, %0d carried one", flagged, checked - flagged);
    if (waiting != 0) begin
      $error("%0d answers never arrived", waiting);
    end
    if (mismatches == 0 && waiting == 0) begin
      $display("fermat_modular_inverse regression: pass");
    end else begin
      $display("fermat_modular_inverse regression: fail");
    end
    $finish;
  end

endmodule
